// ===== rtl/core/sign_magnitude_alu_top_macros.svh =====
// Assertion macros for the sign-magnitude ALU.
`ifndef SIGN_MAGNITUDE_ALU_TOP_MACROS_SVH
`define SIGN_MAGNITUDE_ALU_TOP_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define SMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define SMA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/sma_pkg.sv =====
// Shared types and constants for the sign-magnitude ALU.
package sma_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FIELD_BITS = 32;
	localparam int SCALE_FACTOR = 100000;
	localparam int SCALE_BITS = 17;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [FIELD_BITS-1:0] a_word;
		logic [FIELD_BITS-1:0] b_word;
	} op_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] result_word;
		logic                  overflow;
		logic                  divide_by_zero;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

// ===== rtl/core/sma_addsub.sv =====
// Shared adder/subtractor used by every command.
module sma_addsub
	import sma_pkg::*;
#(
	parameter int WIDTH = WORD_WIDTH_DEF
) (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  logic             sub,
	output logic [WIDTH-1:0] sum,
	output logic             cout
);

	logic [WIDTH-1:0] y_eff;

	// on subtract, cout high means x >= y
	assign y_eff = sub ? ~y : y;
	assign {cout, sum} = {1'b0, x} + {1'b0, y_eff} + (WIDTH + 1)'(sub);

endmodule

// ===== rtl/core/sma_seq.sv =====
// Sequencer and operand registers around the shared adder.
module sma_seq
	import sma_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  op_t       op,
	input  logic      ack,
	output seq_stat_t stat,
	output res_t      res
);

	localparam int MAG = WORD_WIDTH - 1;
	localparam int LW = (MAG > SCALE_BITS) ? MAG : SCALE_BITS;
	localparam int DS = MAG + SCALE_BITS;
	localparam int CW = $clog2(DS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_ADD, S_SWAP, S_MUL, S_MFIN, S_DIV, S_DFIN, S_DONE
	} state_t;

	state_t state_q;

	logic [WORD_WIDTH-1:0] aw, bw;
	logic [MAG-1:0]        in_ma, in_mb;
	logic                  in_sa, in_sb;
	cmd_t                  cmd;

	logic [MAG-1:0]        ma_q, mb_q, acc_q, rem_q;
	logic                  sa_q, sb_q, neg_q, div_q;
	logic [LW-1:0]         mlt_q;
	logic [DS-1:0]         quo_q;
	logic [CW-1:0]         cnt_q;
	logic [WORD_WIDTH-1:0] res_word_q;
	logic                  ovf_q, dbz_q;

	logic [MAG:0]          ux, uy, usum;
	logic                  usub, ucout;
	logic                  mul_big, div_big;

	function automatic logic [WORD_WIDTH-1:0] pack(input logic neg, input logic [MAG-1:0] mag);
		pack = (mag == '0) ? '0 : {neg, mag};
	endfunction

	// operand decode; a zero magnitude never carries a sign
	assign aw    = WORD_WIDTH'(op.a_word);
	assign bw    = WORD_WIDTH'(op.b_word);
	assign in_ma = aw[MAG-1:0];
	assign in_mb = bw[MAG-1:0];
	assign in_sa = aw[MAG] && (in_ma != '0);
	assign in_sb = bw[MAG] && (in_mb != '0);
	assign cmd   = cmd_t'(op.cmd);

	assign mul_big = (acc_q != '0) || ((mlt_q >> MAG) != '0);
	assign div_big = (quo_q >> MAG) != '0;

	always_comb begin
		ux   = '0;
		uy   = '0;
		usub = 1'b0;
		unique case (state_q)
			S_ADD: begin
				ux   = {1'b0, ma_q};
				uy   = {1'b0, mb_q};
				usub = sa_q != sb_q;
			end
			S_SWAP: begin
				ux   = {1'b0, mb_q};
				uy   = {1'b0, ma_q};
				usub = 1'b1;
			end
			S_MUL: begin
				ux = {1'b0, acc_q};
				uy = mlt_q[0] ? {1'b0, ma_q} : '0;
			end
			S_DIV: begin
				ux   = {rem_q, quo_q[DS-1]};
				uy   = {1'b0, mb_q};
				usub = 1'b1;
			end
			default: ;
		endcase
	end

	sma_addsub #(.WIDTH(MAG + 1)) u_addsub (
		.x    (ux),
		.y    (uy),
		.sub  (usub),
		.sum  (usum),
		.cout (ucout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ma_q       <= '0;
			mb_q       <= '0;
			acc_q      <= '0;
			rem_q      <= '0;
			sa_q       <= 1'b0;
			sb_q       <= 1'b0;
			neg_q      <= 1'b0;
			div_q      <= 1'b0;
			mlt_q      <= '0;
			quo_q      <= '0;
			cnt_q      <= '0;
			res_word_q <= '0;
			ovf_q      <= 1'b0;
			dbz_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ma_q  <= in_ma;
						mb_q  <= in_mb;
						sa_q  <= in_sa;
						// subtract flips the sign of a nonzero b
						sb_q  <= (cmd == CMD_SUB) ? (in_sb ^ (in_mb != '0)) : in_sb;
						neg_q <= in_sa ^ in_sb;
						div_q <= cmd == CMD_DIV;
						acc_q <= '0;
						ovf_q <= 1'b0;
						dbz_q <= 1'b0;
						unique case (cmd) inside
							CMD_ADD, CMD_SUB: begin
								state_q <= S_ADD;
							end
							CMD_MUL: begin
								mlt_q   <= LW'(in_mb);
								cnt_q   <= CW'(LW);
								state_q <= S_MUL;
							end
							CMD_DIV: begin
								if (in_mb == '0) begin
									res_word_q <= '0;
									dbz_q      <= 1'b1;
									state_q    <= S_DONE;
								end else begin
									// numerator is |a| * scale, formed by the same loop
									mlt_q   <= LW'(SCALE_FACTOR);
									cnt_q   <= CW'(LW);
									state_q <= S_MUL;
								end
							end
						endcase
					end
				end
				S_ADD: begin
					if (!usub) begin
						res_word_q <= pack(sa_q, usum[MAG-1:0]);
						ovf_q      <= usum[MAG];
						state_q    <= S_DONE;
					end else if (ucout) begin
						res_word_q <= pack(sa_q, usum[MAG-1:0]);
						state_q    <= S_DONE;
					end else begin
						state_q <= S_SWAP;
					end
				end
				S_SWAP: begin
					res_word_q <= pack(sb_q, usum[MAG-1:0]);
					state_q    <= S_DONE;
				end
				S_MUL: begin
					acc_q <= usum[MAG:1];
					mlt_q <= {usum[0], mlt_q[LW-1:1]};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_MFIN;
					end
				end
				S_MFIN: begin
					if (!div_q) begin
						res_word_q <= pack(neg_q, mlt_q[MAG-1:0]);
						ovf_q      <= mul_big;
						state_q    <= S_DONE;
					end else begin
						quo_q   <= DS'({acc_q, mlt_q});
						rem_q   <= '0;
						cnt_q   <= CW'(DS);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ucout ? usum[MAG-1:0] : ux[MAG-1:0];
					quo_q <= {quo_q[DS-2:0], ucout};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					res_word_q <= pack(neg_q, div_big ? '1 : quo_q[MAG-1:0]);
					ovf_q      <= div_big;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.idle = state_q == S_IDLE;
	assign stat.done = state_q == S_DONE;

	assign res.result_word    = FIELD_BITS'(res_word_q);
	assign res.overflow       = ovf_q;
	assign res.divide_by_zero = dbz_q;

endmodule

// ===== rtl/core/sign_magnitude_alu_top.sv =====
// Top level of the sign-magnitude ALU: handshakes, result register, checks.
//
// channel  dir  handshake             payload
// op       in   op_valid / op_ready   op_t  (cmd, a_word, b_word)
// res      out  res_valid / res_ready res_t (result_word, overflow, divide_by_zero)
//
// One transaction at a time through a single shared adder/subtractor.
// Steps from accept to the result transaction:
// Add/subtract: one pass over the adder, plus a swap pass when |b| > |a| on unlike signs.
// Multiply: shift-add over the adder.
// Divide: shift-add for |a|*100000, then restoring division, one bit per cycle; a zero
// divisor goes straight to the result.
// Reset clears all control state. A stalled result waits in its register while the next
// transaction is accepted; op_ready stays low while the sequencer is busy.
`include "sign_magnitude_alu_top_macros.svh"

module sign_magnitude_alu_top
	import sma_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	seq_stat_t stat;
	res_t      seq_res;
	res_t      res_q;
	logic      res_valid_q;
	logic      start;
	logic      ack;

	assign op_ready = stat.idle;
	assign start    = op_valid && op_ready;
	// hand the finished result over once the output register is free
	assign ack      = stat.done && (!res_valid_q || res_ready);

	sma_seq #(.WORD_WIDTH(WORD_WIDTH)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.ack    (ack),
		.stat   (stat),
		.res    (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (ack) begin
				res_valid_q <= 1'b1;
				res_q       <= seq_res;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SMA_ASSERT(a_dbz_clean, (res_valid && res.divide_by_zero) |-> (res.result_word == '0 && !res.overflow), "divide by zero result not clean")
	`SMA_ASSERT_NEXT(a_busy_after_accept, start, !op_ready, "ready after accepted transaction")
	`SMA_ASSERT_NEXT(a_done_held, stat.done && !ack, stat.done, "finished result dropped while output stalled")

endmodule

// ===== dv/tb_sign_magnitude_alu_top.sv =====
// Self-checking testbench for the sign-magnitude ALU top level.
module tb_sign_magnitude_alu_top;
	import sma_pkg::*;

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_ready;
	op_t  op;
	logic res_valid;
	logic res_ready;
	res_t res;

	res_t expected_results[$];
	int   mismatch_count = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	bit   op_held = 0;

	sign_magnitude_alu_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] pack_sm(input logic neg, input logic [30:0] mag);
		pack_sm = (mag == '0) ? 32'h0 : {neg, mag};
	endfunction

	function automatic res_t compute_alu_result(input op_t item);
		logic [30:0] ma;
		logic [30:0] mb;
		logic        sa;
		logic        sb;
		logic [31:0] sum;
		logic [61:0] prod;
		logic [47:0] scaled;
		logic [47:0] quot;
		res_t        r;
		ma = item.a_word[30:0];
		mb = item.b_word[30:0];
		// negative zero is plain zero
		sa = item.a_word[31] && (ma != '0);
		sb = item.b_word[31] && (mb != '0);
		r = '0;
		case (item.cmd)
			CMD_ADD, CMD_SUB: begin
				if (item.cmd == CMD_SUB && mb != '0)
					sb = ~sb;
				if (sa == sb) begin
					sum = {1'b0, ma} + {1'b0, mb};
					r.overflow = sum[31];
					r.result_word = pack_sm(sa, sum[30:0]);
				end else if (ma >= mb) begin
					r.result_word = pack_sm(sa, ma - mb);
				end else begin
					r.result_word = pack_sm(sb, mb - ma);
				end
			end
			CMD_MUL: begin
				prod = {31'h0, ma} * {31'h0, mb};
				r.overflow = |prod[61:31];
				r.result_word = pack_sm(sa ^ sb, prod[30:0]);
			end
			default: begin
				if (mb == '0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					scaled = {17'h0, ma} * 48'(SCALE_FACTOR);
					quot = scaled / {17'h0, mb};
					if (quot > {17'h0, MAG_MAX}) begin
						quot = {17'h0, MAG_MAX};
						r.overflow = 1'b1;
					end
					r.result_word = pack_sm(sa ^ sb, quot[30:0]);
				end
			end
		endcase
		return r;
	endfunction

	// Call at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_op(input op_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			if (op_held) begin
				op_valid <= 1'b0;
				op_held = 0;
			end
			@(posedge clk);
		end
		op <= item;
		op_valid <= 1'b1;
		op_held = 1;
		do @(negedge clk); while (!op_ready);
		expected_results.push_back(compute_alu_result(item));
		@(posedge clk);
	endtask

	task automatic send_cmd(input cmd_t c, input logic [31:0] a, input logic [31:0] b);
		op_t item;
		item.cmd = c;
		item.a_word = a;
		item.b_word = b;
		send_op(item);
	endtask

	task automatic wait_all_results();
		if (op_held) begin
			op_valid <= 1'b0;
			op_held = 0;
		end
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [30:0] rand_mag();
		case ($urandom_range(7))
			0: return '0;
			1: return 31'd1;
			2: return MAG_MAX;
			3: return MAG_MAX - 31'($urandom_range(3));
			4: return 31'($urandom_range(255));
			5: return 31'($urandom & 32'hFFFF);
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic op_t rand_op();
		op_t item;
		item.cmd = 2'($urandom_range(3));
		item.a_word = {1'($urandom_range(1)), rand_mag()};
		item.b_word = {1'($urandom_range(1)), rand_mag()};
		return item;
	endfunction

	task automatic test_add_sub_corners();
		send_cmd(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_ADD, 32'h0000_0005, 32'h8000_0005);
		send_cmd(CMD_ADD, 32'h8000_0000, 32'h8000_0000);
		send_cmd(CMD_ADD, 32'h0000_0003, 32'h8000_0007);
		send_cmd(CMD_SUB, 32'h8000_0000, 32'h0000_0000);
		send_cmd(CMD_SUB, 32'h0000_0001, 32'h7FFF_FFFF);
		send_cmd(CMD_SUB, 32'hFFFF_FFFF, 32'h0000_0001);
		send_cmd(CMD_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_mul_corners();
		send_cmd(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_cmd(CMD_MUL, 32'h8000_0003, 32'h0000_0004);
		send_cmd(CMD_MUL, 32'h8000_0000, 32'h8000_0005);
		// product is exactly 2^31: wraps to zero with overflow
		send_cmd(CMD_MUL, 32'h0001_0000, 32'h8000_8000);
		send_cmd(CMD_MUL, 32'h8000_0001, 32'hFFFF_FFFF);
	endtask

	task automatic test_div_corners();
		send_cmd(CMD_DIV, 32'h0000_0007, 32'h0000_0000);
		send_cmd(CMD_DIV, 32'h8000_0007, 32'h8000_0000);
		send_cmd(CMD_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
		send_cmd(CMD_DIV, 32'h8000_0001, 32'h0000_0003);
		send_cmd(CMD_DIV, 32'h0000_0000, 32'h8000_0005);
		send_cmd(CMD_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		// largest dividend that still fits, then the first that saturates
		send_cmd(CMD_DIV, 32'h0000_53E2, 32'h0000_0001);
		send_cmd(CMD_DIV, 32'h8000_53E3, 32'h0000_0001);
	endtask

	task automatic test_random_traffic(input int count, input int idle, input int stall);
		wait_all_results();
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_op(rand_op());
	endtask

	// sender holds off until the pipeline is empty between bursts
	task automatic test_drain_between_bursts();
		send_idle_pct = 0;
		stall_pct = 50;
		repeat (3) begin
			repeat (10)
				send_op(rand_op());
			wait_all_results();
		end
	endtask

	// result checker: handshake is sampled mid-cycle, taken at the next rising edge
	initial begin : result_check
		res_t exp_res;
		forever begin
			@(negedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transaction: %h", res);
				end else begin
					exp_res = expected_results.pop_front();
					if (res.result_word !== exp_res.result_word ||
							res.overflow !== exp_res.overflow ||
							res.divide_by_zero !== exp_res.divide_by_zero) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result differs: expected word %h ovf %b dbz %b, got word %h ovf %b dbz %b",
								exp_res.result_word, exp_res.overflow, exp_res.divide_by_zero,
								res.result_word, res.overflow, res.divide_by_zero);
					end
				end
			end
			@(posedge clk);
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (op_valid && op_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("sign_magnitude_alu_top: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		op_valid = 1'b0;
		op = '0;
		res_ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_corners();
		test_mul_corners();
		test_div_corners();
		test_random_traffic(350, 0, 0);
		test_random_traffic(350, 67, 0);
		test_random_traffic(350, 0, 67);
		test_random_traffic(350, 28, 28);
		test_drain_between_bursts();

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("sign_magnitude_alu_top: match");
		else
			$display("sign_magnitude_alu_top: mismatch");
		$finish;
	end

endmodule

// ===== sign_magnitude_alu_top.f =====
+incdir+rtl/core
rtl/core/sma_pkg.sv
rtl/core/sma_addsub.sv
rtl/core/sma_seq.sv
rtl/core/sign_magnitude_alu_top.sv
dv/tb_sign_magnitude_alu_top.sv
